/* design/sha_pkg.sv */
// SHA-256 engine shared types, constants and round functions.
package sha_pkg;

   typedef logic [7:0][31:0] sha_words_type;

   typedef struct packed {
      logic load;   // copy block into schedule, chain into work words
      logic step;   // one compression round
      logic feed;   // chain += work words
      logic init;   // chain back to initial hash values
   } sha_ctl_type;

   localparam int unsigned BLOCK_BYTES = 64;
   localparam int unsigned LEN_START   = 56;
   localparam logic [7:0]  PAD_MARK    = 8'h80;

   // request action codes
   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   // element i is chaining word i
   localparam sha_words_type SHA_IV = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_s0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_s1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_s0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_s1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic logic [31:0] choose(input logic [31:0] e, input logic [31:0] f,
                                          input logic [31:0] g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic logic [31:0] majority(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] t);
      logic [31:0] k;
      unique case (t)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = 32'h0;
      endcase
      return k;
   endfunction

endpackage

/* design/sha_chan_if.sv */
// Valid/ready channel interfaces for the SHA-256 request and response words.
interface sha_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, output action, output data_byte, input ready);
   modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface sha_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index, output last_word,
                   input ready);
   modport sink (input valid, input digest_word, input word_index, input last_word,
                 output ready);
endinterface

/* design/sha_msg_sched.sv */
// Block byte buffer and rolling 16-word message schedule.
module sha_msg_sched (
   input  logic                 clock,
   input  sha_pkg::sha_ctl_type ctl,
   input  logic                 byte_en,
   input  logic [7:0]           byte_val,
   output logic [31:0]          w_cur
);

   logic [511:0]      blk_ff, blk_in;
   logic [15:0][31:0] win_ff, win_in;
   logic [31:0]       w_new;

   // first byte of the block ends up in the top lane after 64 shifts
   always_comb begin
      blk_in = blk_ff;
      if (byte_en) begin
         blk_in = {blk_ff[503:0], byte_val};
      end
   end

   assign w_new = sha_pkg::small_s1(win_ff[14]) + win_ff[9] +
                  sha_pkg::small_s0(win_ff[1]) + win_ff[0];

   always_comb begin
      win_in = win_ff;
      if (ctl.load) begin
         for (int i = 0; i < 16; i++) begin
            win_in[i] = blk_ff[511 - 32*i -: 32];
         end
      end else if (ctl.step) begin
         for (int i = 0; i < 15; i++) begin
            win_in[i] = win_ff[i + 1];
         end
         win_in[15] = w_new;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
      win_ff <= win_in;
   end

   assign w_cur = win_ff[0];

endmodule

/* design/sha_round_core.sv */
// Shared SHA-256 round unit with working variables and chaining words.
module sha_round_core (
   input  logic                   clock,
   input  logic                   reset,
   input  sha_pkg::sha_ctl_type   ctl,
   input  logic [5:0]             round_idx,
   input  logic [31:0]            w_cur,
   output sha_pkg::sha_words_type chain
);

   sha_pkg::sha_words_type work_ff, work_in;
   sha_pkg::sha_words_type chain_ff, chain_in;
   logic [31:0] t1, t2;

   assign t1 = work_ff[7] + sha_pkg::big_s1(work_ff[4]) +
               sha_pkg::choose(work_ff[4], work_ff[5], work_ff[6]) +
               sha_pkg::round_k(round_idx) + w_cur;
   assign t2 = sha_pkg::big_s0(work_ff[0]) +
               sha_pkg::majority(work_ff[0], work_ff[1], work_ff[2]);

   always_comb begin
      work_in = work_ff;
      if (ctl.load) begin
         work_in = chain_ff;
      end else if (ctl.step) begin
         work_in[7] = work_ff[6];
         work_in[6] = work_ff[5];
         work_in[5] = work_ff[4];
         work_in[4] = work_ff[3] + t1;
         work_in[3] = work_ff[2];
         work_in[2] = work_ff[1];
         work_in[1] = work_ff[0];
         work_in[0] = t1 + t2;
      end
   end

   always_comb begin
      chain_in = chain_ff;
      if (ctl.init) begin
         chain_in = sha_pkg::SHA_IV;
      end else if (ctl.feed) begin
         for (int i = 0; i < 8; i++) begin
            chain_in[i] = chain_ff[i] + work_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (reset) begin
         chain_ff <= sha_pkg::SHA_IV;
      end else begin
         chain_ff <= chain_in;
      end
   end

   assign chain = chain_ff;

endmodule

/* design/sha256_hash_engine_core.sv */
// SHA-256 streaming hash engine top level: byte intake, padding sequencer, digest output.
// Absorb words are taken one per cycle while the engine is idle; every 64th byte also
// starts a block compression (schedule/work load, 64 rounds, feed-forward add) on the
// single round unit, which does one round per cycle. A finish word first pads the block
// one byte per cycle up to its end, plus a further block of zeros and length when 56 or
// more bytes are pending, compresses each padded block, then presents the eight digest
// words one per cycle while rsp.ready is high; word_index 0 comes first and last_word
// marks word 7. req.ready is high only while the engine is idle.
module sha256_hash_engine_core (
   input  logic           clock,
   input  logic           reset,
   sha_req_if.sink        req,
   sha_rsp_if.source      rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FEED,
      ST_PAD,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [60:0] count_ff, count_in;
   logic [5:0]  round_ff, round_in;
   logic [5:0]  pos_ff, pos_in;
   logic [63:0] len_ff, len_in;
   logic        first_ff, first_in;
   logic        final_ff, final_in;
   logic        pad_ff, pad_in;
   logic [2:0]  idx_ff, idx_in;

   sha_pkg::sha_ctl_type   ctl;
   sha_pkg::sha_words_type chain;
   logic        req_acc, rsp_acc;
   logic        byte_en;
   logic [7:0]  byte_val, pad_byte;
   logic        len_byte;
   logic [31:0] w_cur;

   assign req.ready = (state_ff == ST_IDLE);
   assign req_acc   = req.valid && req.ready;
   assign rsp_acc   = rsp.valid && rsp.ready;

   assign len_byte = !first_ff && final_ff && (pos_ff >= 6'(sha_pkg::LEN_START));
   assign pad_byte = first_ff ? sha_pkg::PAD_MARK : (len_byte ? len_ff[63:56] : 8'h00);

   assign byte_en  = (req_acc && (req.action == sha_pkg::ACT_ABSORB)) ||
                     (state_ff == ST_PAD);
   assign byte_val = (state_ff == ST_PAD) ? pad_byte : req.data_byte;

   assign ctl.load = (state_ff == ST_LOAD);
   assign ctl.step = (state_ff == ST_ROUND);
   assign ctl.feed = (state_ff == ST_FEED);
   assign ctl.init = rsp_acc && (idx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      round_in = round_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      first_in = first_ff;
      final_in = final_ff;
      pad_in   = pad_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               if (req.action == sha_pkg::ACT_ABSORB) begin
                  count_in = count_ff + 61'd1;
                  if (count_ff[5:0] == 6'(sha_pkg::BLOCK_BYTES - 1)) begin
                     state_in = ST_LOAD;
                  end
               end else begin
                  len_in   = {count_ff, 3'b000};
                  pos_in   = count_ff[5:0];
                  first_in = 1'b1;
                  final_in = (count_ff[5:0] < 6'(sha_pkg::LEN_START));
                  pad_in   = 1'b1;
                  state_in = ST_PAD;
               end
            end
         end
         ST_LOAD: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FEED;
            end
         end
         ST_FEED: begin
            if (!pad_ff) begin
               state_in = ST_IDLE;
            end else if (final_ff) begin
               idx_in   = 3'd0;
               state_in = ST_EMIT;
            end else begin
               // length did not fit: one more block of zeros plus length
               final_in = 1'b1;
               state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            first_in = 1'b0;
            pos_in   = pos_ff + 6'd1;
            if (len_byte) begin
               len_in = {len_ff[55:0], 8'h00};
            end
            if (pos_ff == 6'(sha_pkg::BLOCK_BYTES - 1)) begin
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (rsp.ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) begin
                  count_in = '0;
                  pad_in   = 1'b0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      len_ff <= len_in;
      pos_ff <= pos_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         round_ff <= '0;
         first_ff <= 1'b0;
         final_ff <= 1'b0;
         pad_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         round_ff <= round_in;
         first_ff <= first_in;
         final_ff <= final_in;
         pad_ff   <= pad_in;
         idx_ff   <= idx_in;
      end
   end

   assign rsp.valid       = (state_ff == ST_EMIT);
   assign rsp.digest_word = chain[idx_ff];
   assign rsp.word_index  = idx_ff;
   assign rsp.last_word   = (idx_ff == 3'd7);

   sha_msg_sched u_sched (
      .clock    (clock),
      .ctl      (ctl),
      .byte_en  (byte_en),
      .byte_val (byte_val),
      .w_cur    (w_cur)
   );

   sha_round_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .round_idx (round_ff),
      .w_cur     (w_cur),
      .chain     (chain)
   );

   a_round_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_ROUND |-> round_ff == 6'd0)
      else $error("round counter not zero outside compression");

   a_load_round: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_ROUND && round_ff == 6'd0)
      else $error("compression did not start at round zero after load");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp.valid && req.ready))
      else $error("intake open while digest words pending");

   a_msg_done: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && rsp.last_word |=> state_ff == ST_IDLE && count_ff == 61'd0 && !pad_ff)
      else $error("engine not reinitialized after last digest word");

   a_emit_final: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FEED && pad_ff && final_ff |=> rsp.valid && rsp.word_index == 3'd0)
      else $error("digest output did not start at word zero");

endmodule

/* tb/tb_top.sv */
// Testbench for the SHA-256 streaming hash engine: byte stimulus, digest prediction, checks.
`timescale 1ns / 100ps

localparam bit [31:0] ROUND_CONST [64] = '{
   32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
   32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
   32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
   32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
   32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
   32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
   32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
   32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
   32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
   32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
   32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
   32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
   32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
   32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
   32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
   32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
};

localparam bit [31:0] START_CHAIN [8] = '{
   32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
   32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
};

typedef struct {
   bit [31:0] word;
   bit [2:0]  index;
   bit        last;
} digest_word_type;

class sha_scoreboard;
   bit [31:0]       chain [8];
   bit [7:0]        block [64];
   bit [60:0]       byte_total;
   digest_word_type digest_q [$];
   int              error_count;

   function new();
      foreach (chain[i]) chain[i] = START_CHAIN[i];
      byte_total  = '0;
      error_count = 0;
   endfunction

   static function bit [31:0] ror(bit [31:0] x, int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function void compress();
      bit [31:0] sched [16];
      bit [31:0] a, b, c, d, e, f, g, h;
      bit [31:0] t1, t2, s0, s1, w15, w2;
      for (int i = 0; i < 16; i++) begin
         sched[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
      e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
      for (int t = 0; t < 64; t++) begin
         if (t >= 16) begin
            w15 = sched[(t - 15) & 15];
            w2  = sched[(t - 2) & 15];
            s0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
            s1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
            sched[t & 15] = s1 + sched[(t - 7) & 15] + s0 + sched[t & 15];
         end
         t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
              + ROUND_CONST[t] + sched[t & 15];
         t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
      chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
   endfunction

   // accepted request word
   function void note_request(bit act, bit [7:0] data);
      int unsigned     fill;
      bit [63:0]       bit_len;
      digest_word_type dw;
      fill = byte_total[5:0];
      if (act == sha_pkg::ACT_ABSORB) begin
         block[fill] = data;
         byte_total  = byte_total + 61'd1;
         if (fill == 63) compress();
         return;
      end
      bit_len = {byte_total, 3'b000};
      block[fill] = 8'h80;
      for (int i = fill + 1; i < 64; i++) block[i] = 8'h00;
      // no room for the length: extra all-zero block carries it
      if (fill >= 56) begin
         compress();
         for (int i = 0; i < 56; i++) block[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) block[56 + i] = bit_len[63 - 8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
         dw.word  = chain[i];
         dw.index = i[2:0];
         dw.last  = (i == 7);
         digest_q.push_back(dw);
      end
      foreach (chain[i]) chain[i] = START_CHAIN[i];
      byte_total = '0;
   endfunction

   function void check_digest(bit [31:0] word, bit [2:0] index, bit last);
      digest_word_type want;
      if (digest_q.size() == 0) begin
         $error("unexpected digest word %h index %0d last %0d", word, index, last);
         error_count++;
         return;
      end
      want = digest_q.pop_front();
      if (word !== want.word) begin
         $error("digest_word expected %h actual %h", want.word, word);
         error_count++;
      end
      if (index !== want.index) begin
         $error("word_index expected %0d actual %0d", want.index, index);
         error_count++;
      end
      if (last !== want.last) begin
         $error("last_word expected %0d actual %0d", want.last, last);
         error_count++;
      end
   endfunction

   function int pending();
      return digest_q.size();
   endfunction
endclass

module tb_top;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 430;

   logic clock = 1'b0;
   logic reset;

   sha_req_if req_ch ();
   sha_rsp_if rsp_ch ();

   sha256_hash_engine_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   sha_scoreboard board;
   int            src_idle_pct = 0;
   int            snk_stall_pct = 0;
   int            quiet_cycles = 0;
   int            words_sent = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side: check and random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            board.check_digest(rsp_ch.digest_word, rsp_ch.word_index, rsp_ch.last_word);
         end
         rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   task automatic send_word(bit act, bit [7:0] data);
      if ($urandom_range(99) < src_idle_pct) begin
         req_ch.valid <= 1'b0;
         // mostly short gaps, now and then a longer one that can span a compression
         if ($urandom_range(9) == 0) repeat ($urandom_range(5, 80)) @(posedge clock);
         else repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.action    <= act;
      req_ch.data_byte <= data;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(act, data);
      words_sent++;
   endtask

   task automatic hash_random_message(int len);
      for (int i = 0; i < len; i++) send_word(sha_pkg::ACT_ABSORB, 8'($urandom_range(255)));
      send_word(sha_pkg::ACT_FINISH, 8'($urandom_range(255)));
   endtask

   task automatic set_idling(int phase);
      case (phase)
         0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
         1: begin src_idle_pct = 67; snk_stall_pct = 0;  end
         2: begin src_idle_pct = 0;  snk_stall_pct = 67; end
         default: begin src_idle_pct = 20; snk_stall_pct = 20; end
      endcase
   endtask

   initial begin
      int pick;
      int len;
      int phase;
      board = new();
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.action    <= sha_pkg::ACT_ABSORB;
      req_ch.data_byte <= 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, byte extremes, "abc", back-to-back finishes
      set_idling(0);
      send_word(sha_pkg::ACT_FINISH, 8'hff);
      send_word(sha_pkg::ACT_ABSORB, 8'h00);
      send_word(sha_pkg::ACT_FINISH, 8'h00);
      send_word(sha_pkg::ACT_ABSORB, 8'hff);
      send_word(sha_pkg::ACT_FINISH, 8'h5a);
      send_word(sha_pkg::ACT_ABSORB, 8'h61);
      send_word(sha_pkg::ACT_ABSORB, 8'h62);
      send_word(sha_pkg::ACT_ABSORB, 8'h63);
      send_word(sha_pkg::ACT_FINISH, 8'ha5);
      send_word(sha_pkg::ACT_ABSORB, 8'h80);
      send_word(sha_pkg::ACT_FINISH, 8'h00);
      send_word(sha_pkg::ACT_FINISH, 8'h00);

      words_sent = 0;
      while (words_sent < RANDOM_ITEMS) begin
         phase = (words_sent * 4) / RANDOM_ITEMS;
         set_idling(phase);
         // some messages with no idling at all
         if ($urandom_range(7) == 0) begin
            src_idle_pct  = 0;
            snk_stall_pct = 0;
         end
         pick = $urandom_range(99);
         if (pick < 55) len = $urandom_range(0, 20);
         else if (pick < 85) len = $urandom_range(52, 72); // around the length-room edge
         else len = $urandom_range(0, 130);
         // keep the last message inside the word budget
         if (len > RANDOM_ITEMS - words_sent - 1) len = RANDOM_ITEMS - words_sent - 1;
         hash_random_message(len);
      end
      req_ch.valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (board.error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

/* sha256_hash_engine_core.f */
design/sha_pkg.sv
design/sha_chan_if.sv
design/sha_msg_sched.sv
design/sha_round_core.sv
design/sha256_hash_engine_core.sv
tb/tb_top.sv
